/* rtl/core/ohm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohm_pkg
// Shared types, codes and tables for the ordered hash map engine.
// ----------------------------------------------------------------------------
package ohm_pkg;

  localparam int MAX_SLOTS     = 256;
  localparam int SLOT_AW       = 8;
  localparam int CNT_W         = SLOT_AW + 1;
  localparam int WORD_BITS     = 64;
  localparam int PERTURB_SHIFT = 5;
  localparam logic [3:0] START_LOG2 = 4'd3;
  localparam logic [3:0] MAX_LOG2   = 4'd8;

  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_GET   = 3'd1;
  localparam logic [2:0] OP_DEL   = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_POP   = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_DEAD   = 2'd3;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_TOMB  = 2'd1;
  localparam logic [1:0] TAG_LIVE  = 2'd2;

  typedef struct packed {
    logic [2:0]           op;
    logic [WORD_BITS-1:0] key_hash;
    logic [WORD_BITS-1:0] key;
    logic [WORD_BITS-1:0] value;
    logic [7:0]           position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 found;
    logic [WORD_BITS-1:0] key_out;
    logic [WORD_BITS-1:0] value_out;
    logic [CNT_W-1:0]     live_entries;
    logic [CNT_W-1:0]     used_entries;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         tag;
    logic [SLOT_AW-1:0] idx;
  } slot_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] hash;
    logic [WORD_BITS-1:0] key;
    logic [WORD_BITS-1:0] val;
    logic                 live;
  } entry_t;

  typedef struct packed {
    logic               clr;
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    slot_t              wr_data;
  } slot_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    entry_t             wr_data;
  } ent_req_t;

  // (2 * capacity) / 3 for each capacity
  function automatic logic [CNT_W-1:0] grow_thresh(input logic [3:0] l2);
    logic [CNT_W-1:0] t;
    case (l2)
      4'd3:    t = 9'd5;
      4'd4:    t = 9'd10;
      4'd5:    t = 9'd21;
      4'd6:    t = 9'd42;
      4'd7:    t = 9'd85;
      4'd8:    t = 9'd170;
      default: t = 9'd5;
    endcase
    return t;
  endfunction

endpackage

/* rtl/core/ordered_hash_map_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_hash_map_engine
// Hash map with a probe table and an insertion-ordered entry store.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready as one in_item (op, key_hash, key,
// value, position); each gives exactly one out_item on out_valid/out_ready.
// One request is processed at a time. A lookup reads each probed slot from
// the slot memory and, for a live slot, its entry from the entry memory;
// both memories have a registered read. A pop skips dead entries from the
// newest end and, if the slot must be searched, scans the slots in order.
// An insert that crosses two thirds of capacity rebuilds in place: it
// compacts the live entries, then does one probe per live entry. Clear, and
// a read beyond the used entries, read no memory; other reads fetch the entry.
// The result sits in an output register; a new request is taken while it
// waits, and the block holds the next result until the receiver takes it.
// Reset empties the map at once (slot valid bits clear) and sets capacity
// to eight slots; no sweep is needed.
// ----------------------------------------------------------------------------
module ordered_hash_map_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ohm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ohm_pkg::out_item_t out_item
);

  ohm_pkg::slot_req_t slot_req;
  ohm_pkg::slot_t     slot_rd;
  ohm_pkg::ent_req_t  ent_req;
  ohm_pkg::entry_t    ent_rd;

  ohm_slot_mem u_slot (
    .clk     (clk),
    .rst     (rst),
    .req     (slot_req),
    .rd_data (slot_rd)
  );

  ohm_entry_mem u_entry (
    .clk     (clk),
    .req     (ent_req),
    .rd_data (ent_rd)
  );

  ohm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .slot_req  (slot_req),
    .slot_rd   (slot_rd),
    .ent_req   (ent_req),
    .ent_rd    (ent_rd)
  );

endmodule

/* rtl/core/ohm_slot_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohm_slot_mem
// Probe table memory with per-slot valid bits; invalid slots read as empty.
// ----------------------------------------------------------------------------
module ohm_slot_mem (
  input  logic               clk,
  input  logic               rst,
  input  ohm_pkg::slot_req_t req,
  output ohm_pkg::slot_t     rd_data
);

  ohm_pkg::slot_t                  mem [ohm_pkg::MAX_SLOTS];
  logic [ohm_pkg::MAX_SLOTS-1:0]   vld;
  ohm_pkg::slot_t                  q;
  logic                            q_v;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (req.rd_en) begin
      q_v <= vld[req.rd_addr];
    end
  end

  always_comb begin
    rd_data.tag = q_v ? q.tag : ohm_pkg::TAG_EMPTY;
    rd_data.idx = q_v ? q.idx : '0;
  end

endmodule

/* rtl/core/ohm_entry_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohm_entry_mem
// Insertion-ordered entry store, one write and one registered read port.
// ----------------------------------------------------------------------------
module ohm_entry_mem (
  input  logic              clk,
  input  ohm_pkg::ent_req_t req,
  output ohm_pkg::entry_t   rd_data
);

  ohm_pkg::entry_t mem [ohm_pkg::MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* rtl/core/ohm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohm_ctrl
// Sequencer: probing, insert, delete, pop, read, clear and in-place rebuild.
// ----------------------------------------------------------------------------
module ohm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ohm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ohm_pkg::out_item_t out_item,
  output ohm_pkg::slot_req_t slot_req,
  input  ohm_pkg::slot_t     slot_rd,
  output ohm_pkg::ent_req_t  ent_req,
  input  ohm_pkg::entry_t    ent_rd
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_PR_RD   = 16'h0002,
    S_PR_SLOT = 16'h0004,
    S_PR_ENT  = 16'h0008,
    S_PR_END  = 16'h0010,
    S_SET_CHK = 16'h0020,
    S_POP_RD  = 16'h0040,
    S_POP_CHK = 16'h0080,
    S_SC_RD   = 16'h0100,
    S_SC_CHK  = 16'h0200,
    S_RD_CHK  = 16'h0400,
    S_RB_RD   = 16'h0800,
    S_RB_CHK  = 16'h1000,
    S_RI_RD   = 16'h2000,
    S_RI_GOT  = 16'h4000,
    S_RESP    = 16'h8000
  } state_t;

  typedef enum logic [1:0] {C_SET, C_GET, C_POP, C_REB} caller_t;
  typedef enum logic [1:0] {PR_FOUND, PR_ABSENT, PR_NONE} pres_t;

  localparam int AW = ohm_pkg::SLOT_AW;
  localparam int CW = ohm_pkg::CNT_W;
  localparam int WB = ohm_pkg::WORD_BITS;

  state_t              state, state_next;
  ohm_pkg::in_item_t   req, req_next;
  logic [WB-1:0]       pr_hash, pr_hash_next, pr_key, pr_key_next;
  logic [WB-1:0]       pr_perturb, pr_perturb_next;
  logic [AW-1:0]       pr_j, pr_j_next, pr_tomb, pr_tomb_next;
  logic [CW:0]         pr_n, pr_n_next;
  logic                pr_tomb_v, pr_tomb_v_next;
  pres_t               pr_res, pr_res_next;
  logic [AW-1:0]       pr_slot, pr_slot_next, pr_idx, pr_idx_next;
  caller_t             caller, caller_next;
  logic [CW-1:0]       pop_i, pop_i_next;
  ohm_pkg::entry_t     pe, pe_next;
  logic [CW-1:0]       sc_i, sc_i_next;
  logic                sc_match, sc_match_next;
  logic [CW-1:0]       rb_r, rb_r_next, rb_w, rb_w_next, ri_i, ri_i_next;
  logic [3:0]          new_log2, new_log2_next, cap_log2, cap_log2_next;
  logic [CW-1:0]       live_cnt, live_cnt_next, used_cnt, used_cnt_next;
  logic [1:0]          res_status, res_status_next;
  logic                res_found, res_found_next;
  logic [WB-1:0]       res_kout, res_kout_next, res_vout, res_vout_next;
  logic                out_valid_next;
  ohm_pkg::out_item_t  out_item_next;

  logic [CW-1:0]       cap;
  logic [AW-1:0]       mask;
  logic [WB-1:0]       pert_sh;
  logic [AW-1:0]       j_adv;
  logic [AW-1:0]       pop_idx;
  logic                start_pr, adv;
  logic [WB-1:0]       start_h, start_k;
  logic [CW-1:0]       thr;

  assign cap     = CW'(1) << cap_log2;
  assign mask    = AW'(cap - CW'(1));
  assign pert_sh = pr_perturb >> ohm_pkg::PERTURB_SHIFT;
  assign j_adv   = ((pr_j << 2) + pr_j + pert_sh[AW-1:0] + AW'(1)) & mask;
  assign pop_idx = AW'(pop_i - CW'(1));
  assign thr     = ohm_pkg::grow_thresh(cap_log2);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    req_next        = req;
    pr_hash_next    = pr_hash;
    pr_key_next     = pr_key;
    pr_perturb_next = pr_perturb;
    pr_j_next       = pr_j;
    pr_n_next       = pr_n;
    pr_tomb_v_next  = pr_tomb_v;
    pr_tomb_next    = pr_tomb;
    pr_res_next     = pr_res;
    pr_slot_next    = pr_slot;
    pr_idx_next     = pr_idx;
    caller_next     = caller;
    pop_i_next      = pop_i;
    pe_next         = pe;
    sc_i_next       = sc_i;
    sc_match_next   = sc_match;
    rb_r_next       = rb_r;
    rb_w_next       = rb_w;
    ri_i_next       = ri_i;
    new_log2_next   = new_log2;
    cap_log2_next   = cap_log2;
    live_cnt_next   = live_cnt;
    used_cnt_next   = used_cnt;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_kout_next   = res_kout;
    res_vout_next   = res_vout;
    out_valid_next  = out_valid && !out_ready;
    out_item_next   = out_item;
    slot_req        = '0;
    ent_req         = '0;
    start_pr        = 1'b0;
    adv             = 1'b0;
    start_h         = '0;
    start_k         = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next        = in_item;
          res_status_next = ohm_pkg::ST_OK;
          res_found_next  = 1'b0;
          res_kout_next   = '0;
          res_vout_next   = '0;
          case (in_item.op)
            ohm_pkg::OP_SET: begin
              caller_next = C_SET;
              start_pr    = 1'b1;
              start_h     = in_item.key_hash;
              start_k     = in_item.key;
            end
            ohm_pkg::OP_GET, ohm_pkg::OP_DEL: begin
              caller_next = C_GET;
              start_pr    = 1'b1;
              start_h     = in_item.key_hash;
              start_k     = in_item.key;
            end
            ohm_pkg::OP_CLEAR: begin
              slot_req.clr  = 1'b1;
              used_cnt_next = '0;
              live_cnt_next = '0;
              state_next    = S_RESP;
            end
            ohm_pkg::OP_POP: begin
              pop_i_next = used_cnt;
              state_next = S_POP_RD;
            end
            ohm_pkg::OP_READ: begin
              if (CW'(in_item.position) < used_cnt) begin
                ent_req.rd_en   = 1'b1;
                ent_req.rd_addr = in_item.position;
                state_next      = S_RD_CHK;
              end else begin
                res_status_next = ohm_pkg::ST_DEAD;
                state_next      = S_RESP;
              end
            end
            default: state_next = S_RESP;
          endcase
        end
      end

      S_PR_RD: begin
        if (pr_n == {cap, 1'b0}) begin
          pr_res_next  = pr_tomb_v ? PR_ABSENT : PR_NONE;
          pr_slot_next = pr_tomb;
          state_next   = S_PR_END;
        end else begin
          slot_req.rd_en   = 1'b1;
          slot_req.rd_addr = pr_j;
          state_next       = S_PR_SLOT;
        end
      end

      S_PR_SLOT: begin
        if (slot_rd.tag == ohm_pkg::TAG_EMPTY) begin
          pr_res_next  = PR_ABSENT;
          pr_slot_next = pr_tomb_v ? pr_tomb : pr_j;
          state_next   = S_PR_END;
        end else if (slot_rd.tag == ohm_pkg::TAG_TOMB) begin
          if (!pr_tomb_v) begin
            pr_tomb_v_next = 1'b1;
            pr_tomb_next   = pr_j;
          end
          adv = 1'b1;
        end else begin
          ent_req.rd_en   = 1'b1;
          ent_req.rd_addr = slot_rd.idx;
          pr_idx_next     = slot_rd.idx;
          state_next      = S_PR_ENT;
        end
      end

      S_PR_ENT: begin
        if (ent_rd.live && ent_rd.hash == pr_hash && ent_rd.key == pr_key) begin
          pr_res_next  = PR_FOUND;
          pr_slot_next = pr_j;
          state_next   = S_PR_END;
        end else begin
          adv = 1'b1;
        end
      end

      S_PR_END: begin
        case (caller)
          C_SET: begin
            if (pr_res == PR_FOUND) begin
              res_found_next        = 1'b1;
              res_vout_next         = ent_rd.val;
              ent_req.wr_en         = 1'b1;
              ent_req.wr_addr       = pr_idx;
              ent_req.wr_data       = '{hash: pr_hash, key: pr_key, val: req.value, live: 1'b1};
              state_next            = S_RESP;
            end else if (pr_res == PR_NONE || used_cnt >= cap) begin
              res_status_next = ohm_pkg::ST_FULL;
              state_next      = S_RESP;
            end else begin
              ent_req.wr_en    = 1'b1;
              ent_req.wr_addr  = AW'(used_cnt);
              ent_req.wr_data  = '{hash: pr_hash, key: pr_key, val: req.value, live: 1'b1};
              slot_req.wr_en   = 1'b1;
              slot_req.wr_addr = pr_slot;
              slot_req.wr_data = '{tag: ohm_pkg::TAG_LIVE, idx: AW'(used_cnt)};
              used_cnt_next    = used_cnt + CW'(1);
              live_cnt_next    = live_cnt + CW'(1);
              state_next       = S_SET_CHK;
            end
          end
          C_GET: begin
            if (pr_res == PR_FOUND) begin
              res_found_next = 1'b1;
              res_vout_next  = ent_rd.val;
              if (req.op == ohm_pkg::OP_DEL) begin
                ent_req.wr_en    = 1'b1;
                ent_req.wr_addr  = pr_idx;
                ent_req.wr_data  = '{hash: ent_rd.hash, key: ent_rd.key, val: ent_rd.val,
                                     live: 1'b0};
                slot_req.wr_en   = 1'b1;
                slot_req.wr_addr = pr_slot;
                slot_req.wr_data = '{tag: ohm_pkg::TAG_TOMB, idx: '0};
                if (live_cnt != '0) live_cnt_next = live_cnt - CW'(1);
              end
            end else begin
              res_status_next = ohm_pkg::ST_ABSENT;
            end
            state_next = S_RESP;
          end
          C_POP: begin
            if (pr_res == PR_FOUND && pr_idx == pop_idx) begin
              ent_req.wr_en    = 1'b1;
              ent_req.wr_addr  = pop_idx;
              ent_req.wr_data  = '{hash: pe.hash, key: pe.key, val: pe.val, live: 1'b0};
              slot_req.wr_en   = 1'b1;
              slot_req.wr_addr = pr_slot;
              slot_req.wr_data = '{tag: ohm_pkg::TAG_TOMB, idx: '0};
              if (live_cnt != '0) live_cnt_next = live_cnt - CW'(1);
              state_next = S_RESP;
            end else begin
              sc_match_next = 1'b1;
              sc_i_next     = '0;
              state_next    = S_SC_RD;
            end
          end
          default: begin
            if (pr_res == PR_ABSENT) begin
              slot_req.wr_en   = 1'b1;
              slot_req.wr_addr = pr_slot;
              slot_req.wr_data = '{tag: ohm_pkg::TAG_LIVE, idx: AW'(ri_i)};
              used_cnt_next    = used_cnt + CW'(1);
              live_cnt_next    = live_cnt + CW'(1);
              ri_i_next        = ri_i + CW'(1);
              state_next       = S_RI_RD;
            end else begin
              sc_match_next = 1'b0;
              sc_i_next     = '0;
              state_next    = S_SC_RD;
            end
          end
        endcase
      end

      S_SET_CHK: begin
        if (used_cnt > thr) begin
          if (live_cnt > (thr >> 1) && cap_log2 < ohm_pkg::MAX_LOG2) begin
            new_log2_next = cap_log2 + 4'd1;
          end else begin
            new_log2_next = cap_log2;
          end
          rb_r_next  = '0;
          rb_w_next  = '0;
          state_next = S_RB_RD;
        end else begin
          state_next = S_RESP;
        end
      end

      S_POP_RD: begin
        if (pop_i == '0) begin
          res_status_next = ohm_pkg::ST_ABSENT;
          state_next      = S_RESP;
        end else begin
          ent_req.rd_en   = 1'b1;
          ent_req.rd_addr = pop_idx;
          state_next      = S_POP_CHK;
        end
      end

      S_POP_CHK: begin
        if (!ent_rd.live) begin
          pop_i_next = pop_i - CW'(1);
          state_next = S_POP_RD;
        end else begin
          pe_next        = ent_rd;
          res_kout_next  = ent_rd.key;
          res_vout_next  = ent_rd.val;
          res_found_next = 1'b1;
          caller_next    = C_POP;
          start_pr       = 1'b1;
          start_h        = ent_rd.hash;
          start_k        = ent_rd.key;
        end
      end

      S_SC_RD: begin
        if (sc_i == cap) begin
          if (sc_match) begin
            ent_req.wr_en   = 1'b1;
            ent_req.wr_addr = pop_idx;
            ent_req.wr_data = '{hash: pe.hash, key: pe.key, val: pe.val, live: 1'b0};
            if (live_cnt != '0) live_cnt_next = live_cnt - CW'(1);
            state_next = S_RESP;
          end else begin
            slot_req.wr_en   = 1'b1;
            slot_req.wr_addr = '0;
            slot_req.wr_data = '{tag: ohm_pkg::TAG_LIVE, idx: AW'(ri_i)};
            used_cnt_next    = used_cnt + CW'(1);
            live_cnt_next    = live_cnt + CW'(1);
            ri_i_next        = ri_i + CW'(1);
            state_next       = S_RI_RD;
          end
        end else begin
          slot_req.rd_en   = 1'b1;
          slot_req.rd_addr = AW'(sc_i);
          state_next       = S_SC_CHK;
        end
      end

      S_SC_CHK: begin
        if (sc_match && slot_rd.tag == ohm_pkg::TAG_LIVE && slot_rd.idx == pop_idx) begin
          ent_req.wr_en    = 1'b1;
          ent_req.wr_addr  = pop_idx;
          ent_req.wr_data  = '{hash: pe.hash, key: pe.key, val: pe.val, live: 1'b0};
          slot_req.wr_en   = 1'b1;
          slot_req.wr_addr = AW'(sc_i);
          slot_req.wr_data = '{tag: ohm_pkg::TAG_TOMB, idx: '0};
          if (live_cnt != '0) live_cnt_next = live_cnt - CW'(1);
          state_next = S_RESP;
        end else if (!sc_match && slot_rd.tag == ohm_pkg::TAG_EMPTY) begin
          slot_req.wr_en   = 1'b1;
          slot_req.wr_addr = AW'(sc_i);
          slot_req.wr_data = '{tag: ohm_pkg::TAG_LIVE, idx: AW'(ri_i)};
          used_cnt_next    = used_cnt + CW'(1);
          live_cnt_next    = live_cnt + CW'(1);
          ri_i_next        = ri_i + CW'(1);
          state_next       = S_RI_RD;
        end else begin
          sc_i_next  = sc_i + CW'(1);
          state_next = S_SC_RD;
        end
      end

      S_RD_CHK: begin
        if (ent_rd.live) begin
          res_found_next = 1'b1;
          res_kout_next  = ent_rd.key;
          res_vout_next  = ent_rd.val;
        end else begin
          res_status_next = ohm_pkg::ST_DEAD;
        end
        state_next = S_RESP;
      end

      S_RB_RD: begin
        if (rb_r == used_cnt) begin
          cap_log2_next = new_log2;
          slot_req.clr  = 1'b1;
          used_cnt_next = '0;
          live_cnt_next = '0;
          ri_i_next     = '0;
          state_next    = S_RI_RD;
        end else begin
          ent_req.rd_en   = 1'b1;
          ent_req.rd_addr = AW'(rb_r);
          state_next      = S_RB_CHK;
        end
      end

      S_RB_CHK: begin
        if (ent_rd.live) begin
          ent_req.wr_en   = 1'b1;
          ent_req.wr_addr = AW'(rb_w);
          ent_req.wr_data = ent_rd;
          rb_w_next       = rb_w + CW'(1);
        end
        rb_r_next  = rb_r + CW'(1);
        state_next = S_RB_RD;
      end

      S_RI_RD: begin
        if (ri_i == rb_w) begin
          state_next = S_RESP;
        end else begin
          ent_req.rd_en   = 1'b1;
          ent_req.rd_addr = AW'(ri_i);
          state_next      = S_RI_GOT;
        end
      end

      S_RI_GOT: begin
        caller_next = C_REB;
        start_pr    = 1'b1;
        start_h     = ent_rd.hash;
        start_k     = ent_rd.key;
      end

      S_RESP: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_item_next  = '{status: res_status, found: res_found, key_out: res_kout,
                             value_out: res_vout, live_entries: live_cnt,
                             used_entries: used_cnt};
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    if (adv) begin
      pr_perturb_next = pert_sh;
      pr_j_next       = j_adv;
      pr_n_next       = pr_n + (CW+1)'(1);
      state_next      = S_PR_RD;
    end

    if (start_pr) begin
      pr_hash_next    = start_h;
      pr_key_next     = start_k;
      pr_perturb_next = start_h;
      pr_j_next       = start_h[AW-1:0] & mask;
      pr_n_next       = '0;
      pr_tomb_v_next  = 1'b0;
      state_next      = S_PR_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cap_log2  <= ohm_pkg::START_LOG2;
      live_cnt  <= '0;
      used_cnt  <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cap_log2  <= cap_log2_next;
      live_cnt  <= live_cnt_next;
      used_cnt  <= used_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    pr_hash    <= pr_hash_next;
    pr_key     <= pr_key_next;
    pr_perturb <= pr_perturb_next;
    pr_j       <= pr_j_next;
    pr_n       <= pr_n_next;
    pr_tomb_v  <= pr_tomb_v_next;
    pr_tomb    <= pr_tomb_next;
    pr_res     <= pr_res_next;
    pr_slot    <= pr_slot_next;
    pr_idx     <= pr_idx_next;
    caller     <= caller_next;
    pop_i      <= pop_i_next;
    pe         <= pe_next;
    sc_i       <= sc_i_next;
    sc_match   <= sc_match_next;
    rb_r       <= rb_r_next;
    rb_w       <= rb_w_next;
    ri_i       <= ri_i_next;
    new_log2   <= new_log2_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_kout   <= res_kout_next;
    res_vout   <= res_vout_next;
    out_item   <= out_item_next;
  end

endmodule
